@@ hdl/mandelbrot_escape_time_defines.svh @@
// Assertion macros shared by the RTL files.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define MBE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define MBE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBE_ASSERT(label, clk, rst, prop, msg)
`define MBE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hdl/mbe_pkg.sv @@
package mbe_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC      = 28;
   localparam int STEP_W    = 31;
   localparam int PIX_W     = 12;
   localparam int WIDE_W    = 48;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int COUNT_W   = 10;
   localparam int COUNT_MAX = 1023;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int FQ_DEPTH  = 2;
   localparam int FQ_PTR_W  = 1;

   localparam logic signed [WIDE_W-1:0] ESCAPE_LIMIT = WIDE_W'(4) <<< FRAC;

   localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd671088640;
   localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST = -32'sd268435456;
   localparam logic [STEP_W-1:0]         X_STEP_RST   = 31'd1565873;
   localparam logic [STEP_W-1:0]         Y_STEP_RST   = 31'd894785;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN = 2'd0,
      CSR_Y_ORIGIN = 2'd1,
      CSR_X_STEP   = 2'd2,
      CSR_Y_STEP   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_origin;
      logic signed [COORD_W-1:0] y_origin;
      logic [STEP_W-1:0]         x_step;
      logic [STEP_W-1:0]         y_step;
   } view_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cr;
      logic signed [COORD_W-1:0] ci;
   } point_type;

   // Clamp a wide signed value to the signed coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [WIDE_W-1:0] v
   );
      logic in_range;
      in_range = (&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1]);
      if (in_range) begin
         return v[COORD_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage

@@ hdl/mbe_front.sv @@
`include "mandelbrot_escape_time_defines.svh"

module mbe_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [mbe_pkg::PIX_W-1:0]      req_pixel_column,
   input  logic [mbe_pkg::PIX_W-1:0]      req_pixel_row,
   input  mbe_pkg::view_type              view,
   output logic                           c_valid,
   input  logic                           c_ready,
   output mbe_pkg::point_type             c_data
);

   localparam int MUL_W = mbe_pkg::PIX_W + mbe_pkg::STEP_W;

   mbe_pkg::point_type                 fq_mem_ff [mbe_pkg::FQ_DEPTH];
   logic [mbe_pkg::FQ_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mbe_pkg::FQ_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mbe_pkg::FQ_PTR_W:0]         count_ff, count_in;

   logic [MUL_W-1:0]                   prod_x, prod_y;
   logic signed [mbe_pkg::WIDE_W-1:0]  wide_x, wide_y;
   mbe_pkg::point_type                 point;
   logic                               do_push, do_pop;

   // Map the pixel to its point in the plane.
   always_comb begin
      prod_x = MUL_W'(req_pixel_column) * MUL_W'(view.x_step);
      prod_y = MUL_W'(req_pixel_row) * MUL_W'(view.y_step);
      wide_x = mbe_pkg::WIDE_W'(view.x_origin) + mbe_pkg::WIDE_W'($signed({1'b0, prod_x}));
      wide_y = mbe_pkg::WIDE_W'(view.y_origin) + mbe_pkg::WIDE_W'($signed({1'b0, prod_y}));
      point.cr = mbe_pkg::sat_coord(wide_x);
      point.ci = mbe_pkg::sat_coord(wide_y);
   end

   assign full    = (count_ff == (mbe_pkg::FQ_PTR_W+1)'(mbe_pkg::FQ_DEPTH));
   assign c_valid = (count_ff != '0);
   assign c_data  = fq_mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = c_valid && c_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fq_mem_ff[wr_ptr_ff] <= point;
      end
   end

   `MBE_ASSERT(a_fq_bound, clock, reset, count_ff <= (mbe_pkg::FQ_PTR_W+1)'(mbe_pkg::FQ_DEPTH), "point queue overfilled")

endmodule

@@ hdl/mbe_iter.sv @@
`include "mandelbrot_escape_time_defines.svh"

module mbe_iter #(
   parameter int MAX_ITERATIONS = 1000
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           c_valid,
   output logic                           c_ready,
   input  mbe_pkg::point_type             c_data,
   output logic                           res_valid,
   input  logic                           res_ready,
   output logic [mbe_pkg::COUNT_W-1:0]    res_count
);

   localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_ADD  = 4'b0100,
      ST_DONE = 4'b1000
   } iter_state_type;

   iter_state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic signed [mbe_pkg::COORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [mbe_pkg::COORD_W-1:0]   cr_ff, cr_in, ci_ff, ci_in;
   logic signed [mbe_pkg::PROD_W-1:0]    px_ff, px_in, py_ff, py_in, pxy_ff, pxy_in;

   logic signed [mbe_pkg::PROD_W-mbe_pkg::FRAC-1:0] xx, yy;
   logic signed [mbe_pkg::PROD_W-mbe_pkg::FRAC:0]   xy2;
   logic signed [mbe_pkg::WIDE_W-1:0]   nx_wide, ny_wide, mag_sq;
   logic                                 stop;

   // Floor shifts of the registered products.
   always_comb begin
      xx      = px_ff[mbe_pkg::PROD_W-1:mbe_pkg::FRAC];
      yy      = py_ff[mbe_pkg::PROD_W-1:mbe_pkg::FRAC];
      xy2     = pxy_ff[mbe_pkg::PROD_W-1:mbe_pkg::FRAC-1];
      mag_sq  = mbe_pkg::WIDE_W'(xx) + mbe_pkg::WIDE_W'(yy);
      nx_wide = mbe_pkg::WIDE_W'(xx) - mbe_pkg::WIDE_W'(yy) + mbe_pkg::WIDE_W'(cr_ff);
      ny_wide = mbe_pkg::WIDE_W'(xy2) + mbe_pkg::WIDE_W'(ci_ff);
      stop    = (mag_sq >= mbe_pkg::ESCAPE_LIMIT) || (count_ff >= CNT_W'(MAX_ITERATIONS));
   end

   assign c_ready   = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_count = (32'(count_ff) > 32'(mbe_pkg::COUNT_MAX)) ?
                      mbe_pkg::COUNT_W'(mbe_pkg::COUNT_MAX) : mbe_pkg::COUNT_W'(count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pxy_in   = pxy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (c_valid) begin
               cr_in    = c_data.cr;
               ci_in    = c_data.ci;
               x_in     = '0;
               y_in     = '0;
               px_in    = '0;
               py_in    = '0;
               pxy_in   = '0;
               count_in = '0;
               state_in = ST_ADD;
            end
         end
         ST_MUL: begin
            px_in    = x_ff * x_ff;
            py_in    = y_ff * y_ff;
            pxy_in   = x_ff * y_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (stop) begin
               state_in = ST_DONE;
            end else begin
               x_in     = mbe_pkg::sat_coord(nx_wide);
               y_in     = mbe_pkg::sat_coord(ny_wide);
               count_in = count_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      pxy_ff <= pxy_in;
   end

   `MBE_ASSERT(a_count_limit, clock, reset, count_ff <= CNT_W'(MAX_ITERATIONS), "iteration count beyond limit")
   `MBE_ASSERT(a_mul_then_add, clock, reset, (state_ff == ST_MUL) |=> (state_ff == ST_ADD), "multiply not followed by update")
   `MBE_ASSERT(a_done_hold, clock, reset, (state_ff == ST_DONE && !res_ready) |=> (state_ff == ST_DONE && $stable(count_ff)), "result changed while stalled")

endmodule

@@ hdl/mandelbrot_escape_time.sv @@
// Escape-time engine for the Mandelbrot set. Each pixel (column, row) pushed in
// is mapped to c = origin + index * step in signed Q4.28 and iterated as
// z = z*z + c until |z|^2 reaches 4 or MAX_ITERATIONS is reached; one
// escape_count comes out per pixel, in order. Pixels enter a two-entry point
// queue at up to one per cycle while it is not full; the iteration loop takes
// one pixel at a time and alternates the registered multiply stage with the
// shift, add and escape-test stage. Write the view registers only while
// no pixel is in flight.
module mandelbrot_escape_time #(
   parameter int MAX_ITERATIONS = 1000
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [mbe_pkg::PIX_W-1:0]          req_pixel_column,
   input  logic [mbe_pkg::PIX_W-1:0]          req_pixel_row,
   output logic                               empty,
   input  logic                               pop,
   output logic [mbe_pkg::COUNT_W-1:0]        rsp_escape_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbe_pkg::CSR_DAT_W-1:0]      csr_data
);

   mbe_pkg::view_type               view_ff, view_in;
   logic                            rsp_full_ff, rsp_full_in;
   logic [mbe_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                            c_valid, c_ready;
   mbe_pkg::point_type              c_data;
   logic                            res_valid, res_ready;
   logic [mbe_pkg::COUNT_W-1:0]     res_count;

   assign csr_ready = 1'b1;

   always_comb begin
      view_in = view_ff;
      if (csr_valid) begin
         case (mbe_pkg::csr_index_type'(csr_index))
            mbe_pkg::CSR_X_ORIGIN: view_in.x_origin = csr_data;
            mbe_pkg::CSR_Y_ORIGIN: view_in.y_origin = csr_data;
            mbe_pkg::CSR_X_STEP:   view_in.x_step   = csr_data[mbe_pkg::STEP_W-1:0];
            mbe_pkg::CSR_Y_STEP:   view_in.y_step   = csr_data[mbe_pkg::STEP_W-1:0];
            default:               view_in = view_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff.x_origin <= mbe_pkg::X_ORIGIN_RST;
         view_ff.y_origin <= mbe_pkg::Y_ORIGIN_RST;
         view_ff.x_step   <= mbe_pkg::X_STEP_RST;
         view_ff.y_step   <= mbe_pkg::Y_STEP_RST;
      end else begin
         view_ff <= view_in;
      end
   end

   mbe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .view             (view_ff),
      .c_valid          (c_valid),
      .c_ready          (c_ready),
      .c_data           (c_data)
   );

   mbe_iter #(
      .MAX_ITERATIONS (MAX_ITERATIONS)
   ) u_iter (
      .clock     (clock),
      .reset     (reset),
      .c_valid   (c_valid),
      .c_ready   (c_ready),
      .c_data    (c_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_count (res_count)
   );

   // Output slot: refill in the same cycle the waiting beat is popped.
   assign res_ready = !rsp_full_ff || pop;

   always_comb begin
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      if (res_valid && res_ready) begin
         rsp_full_in  = 1'b1;
         rsp_count_in = res_count;
      end else if (pop) begin
         rsp_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_full_ff <= 1'b0;
      end else begin
         rsp_full_ff <= rsp_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign empty            = !rsp_full_ff;
   assign rsp_escape_count = rsp_count_ff;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   localparam int     ITER_LIMIT  = 1000;
   localparam longint TIMEOUT_NS  = 24_000_000;
   localparam longint COORD_HI    = (longint'(1) <<< 31) - 1;
   localparam longint COORD_LO    = -(longint'(1) <<< 31);
   localparam longint RADIUS_SQ   = longint'(4) <<< mbe_pkg::FRAC;
   localparam int     ONE_Q       = 1 << mbe_pkg::FRAC;

   typedef struct {
      logic [mbe_pkg::PIX_W-1:0]   column;
      logic [mbe_pkg::PIX_W-1:0]   row;
      logic [mbe_pkg::COUNT_W-1:0] count;
   } escape_entry_type;

   logic                          clock;
   logic                          reset;
   logic                          push;
   logic                          full;
   logic [mbe_pkg::PIX_W-1:0]     req_pixel_column;
   logic [mbe_pkg::PIX_W-1:0]     req_pixel_row;
   logic                          empty;
   logic                          pop;
   logic [mbe_pkg::COUNT_W-1:0]   rsp_escape_count;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [mbe_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mbe_pkg::CSR_DAT_W-1:0] csr_data;

   mbe_pkg::view_type view;
   escape_entry_type  expected_escapes[$];
   escape_entry_type  head;
   int                error_count   = 0;
   int                send_idle_pct = 0;
   int                pop_stall_pct = 0;

   mandelbrot_escape_time #(
      .MAX_ITERATIONS(ITER_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .empty            (empty),
      .pop              (pop),
      .rsp_escape_count (rsp_escape_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_HI) begin
         return COORD_HI;
      end else if (v < COORD_LO) begin
         return COORD_LO;
      end
      return v;
   endfunction

   // Iterate z = z*z + c in Q4.28; floor shifts drop the low product bits.
   function automatic logic [mbe_pkg::COUNT_W-1:0] escape_time(
      input logic [mbe_pkg::PIX_W-1:0] col,
      input logic [mbe_pkg::PIX_W-1:0] row
   );
      longint      cr, ci, x, y, xx, yy, nx, ny;
      int unsigned n;
      cr = clamp_coord(longint'($signed(view.x_origin)) + longint'(col) * longint'(view.x_step));
      ci = clamp_coord(longint'($signed(view.y_origin)) + longint'(row) * longint'(view.y_step));
      x  = 0;
      y  = 0;
      xx = 0;
      yy = 0;
      n  = 0;
      while (xx + yy < RADIUS_SQ && n < ITER_LIMIT) begin
         nx = clamp_coord(xx - yy + cr);
         ny = clamp_coord(((x * y) >>> (mbe_pkg::FRAC - 1)) + ci);
         x  = nx;
         y  = ny;
         n++;
         xx = (x * x) >>> mbe_pkg::FRAC;
         yy = (y * y) >>> mbe_pkg::FRAC;
      end
      if (n > mbe_pkg::COUNT_MAX) begin
         n = mbe_pkg::COUNT_MAX;
      end
      return n[mbe_pkg::COUNT_W-1:0];
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic csr_write(input mbe_pkg::csr_index_type idx,
                            input logic [mbe_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         mbe_pkg::CSR_X_ORIGIN: view.x_origin = data;
         mbe_pkg::CSR_Y_ORIGIN: view.y_origin = data;
         mbe_pkg::CSR_X_STEP:   view.x_step   = data[mbe_pkg::STEP_W-1:0];
         mbe_pkg::CSR_Y_STEP:   view.y_step   = data[mbe_pkg::STEP_W-1:0];
         default:               view = view;
      endcase
   endtask

   // Call only with no pixel in flight.
   task automatic set_view(
      input logic [mbe_pkg::CSR_DAT_W-1:0] x_origin,
      input logic [mbe_pkg::CSR_DAT_W-1:0] y_origin,
      input logic [mbe_pkg::CSR_DAT_W-1:0] x_step,
      input logic [mbe_pkg::CSR_DAT_W-1:0] y_step
   );
      csr_write(mbe_pkg::CSR_X_ORIGIN, x_origin);
      csr_write(mbe_pkg::CSR_Y_ORIGIN, y_origin);
      csr_write(mbe_pkg::CSR_X_STEP, x_step);
      csr_write(mbe_pkg::CSR_Y_STEP, y_step);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [mbe_pkg::PIX_W-1:0] col,
                             input logic [mbe_pkg::PIX_W-1:0] row);
      escape_entry_type e;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         push <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      push             <= 1'b1;
      req_pixel_column <= col;
      req_pixel_row    <= row;
      @(posedge clock);
      while (full) @(posedge clock);
      e.column = col;
      e.row    = row;
      e.count  = escape_time(col, row);
      expected_escapes.push_back(e);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (expected_escapes.size() != 0) @(posedge clock);
   endtask

   // Pixels under the view left by reset, including saturated c.
   task automatic test_reset_view();
      send_pixel(0, 0);
      send_pixel(428, 300);
      send_pixel(4095, 4095);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(115, 430);
      wait_drained();
   endtask

   // Zero steps pin c to the origin: escape on equality, slow escape, bounded orbits.
   task automatic test_fixed_points();
      logic [mbe_pkg::CSR_DAT_W-1:0] c_re[7];
      logic [mbe_pkg::CSR_DAT_W-1:0] c_im[7];
      c_re = '{-2 * ONE_Q, ONE_Q / 4, -(3 * ONE_Q / 4), 69793218, 0,
               32'h8000_0000, 32'h7FFF_FFFF};
      c_im = '{0, 0, 26843546, 0, ONE_Q, 32'h8000_0000, 32'h7FFF_FFFF};
      for (int i = 0; i < 7; i++) begin
         set_view(c_re[i], c_im[i], 32'h8000_0000 * $urandom_range(1), 0);
         send_pixel(mbe_pkg::PIX_W'($urandom_range(4095)),
                    mbe_pkg::PIX_W'($urandom_range(4095)));
         wait_drained();
      end
   endtask

   // Largest steps with extreme origins, then smallest steps with a zero origin.
   task automatic test_extreme_steps();
      set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(1, 1);
      send_pixel(0, 4095);
      wait_drained();
      set_view(0, 0, 1, 32'h8000_0001);
      send_pixel(4095, 4095);
      send_pixel(0, 0);
      wait_drained();
   endtask

   // Random views and pixels, mostly aimed at the interesting part of the plane.
   task automatic test_random_views();
      int span_cols, span_rows;
      int x_org, y_org;
      bit aimed;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 75; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 75; end
            default: begin send_idle_pct = 9; pop_stall_pct = 9; end
         endcase
         aimed = (phase % 3 != 2);
         span_cols = $urandom_range(8, 600);
         span_rows = $urandom_range(8, 600);
         if (aimed) begin
            x_org = -(9 << 26) + int'($urandom_range(0, 1 << 27)) - (1 << 26);
            y_org = -(5 << 26) + int'($urandom_range(0, 1 << 26)) - (1 << 25);
            set_view(x_org, y_org,
                     {1'($urandom_range(1)), 31'((3 * ONE_Q) / span_cols)},
                     {1'($urandom_range(1)), 31'((5 * ONE_Q / 2) / span_rows)});
         end else begin
            set_view($urandom, $urandom, $urandom, $urandom);
         end
         for (int i = 0; i < 50; i++) begin
            if (aimed && $urandom_range(99) < 80) begin
               send_pixel(mbe_pkg::PIX_W'($urandom_range(span_cols + 16)),
                          mbe_pkg::PIX_W'($urandom_range(span_rows + 16)));
            end else begin
               send_pixel(mbe_pkg::PIX_W'($urandom_range(4095)),
                          mbe_pkg::PIX_W'($urandom_range(4095)));
            end
         end
         wait_drained();
      end
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_escapes.size() == 0) begin
            note_error($sformatf("escape_count %0d popped with no pixel outstanding",
                                 rsp_escape_count));
         end else begin
            head = expected_escapes.pop_front();
            if (rsp_escape_count !== head.count) begin
               note_error($sformatf("pixel (%0d,%0d): escape_count expected %0d, got %0d",
                                    head.column, head.row, head.count, rsp_escape_count));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      push             = 1'b0;
      req_pixel_column = '0;
      req_pixel_row    = '0;
      csr_valid        = 1'b0;
      csr_index        = mbe_pkg::CSR_X_ORIGIN;
      csr_data         = '0;
      view.x_origin    = mbe_pkg::X_ORIGIN_RST;
      view.y_origin    = mbe_pkg::Y_ORIGIN_RST;
      view.x_step      = mbe_pkg::X_STEP_RST;
      view.y_step      = mbe_pkg::Y_STEP_RST;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_view();
      test_fixed_points();
      test_extreme_steps();
      test_random_views();

      wait_drained();
      repeat (2 * ITER_LIMIT + 8) @(posedge clock);
      if (expected_escapes.size() != 0) begin
         note_error($sformatf("%0d escape counts never arrived", expected_escapes.size()));
      end
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mbe_pkg.sv
hdl/mbe_front.sv
hdl/mbe_iter.sv
hdl/mandelbrot_escape_time.sv
bench/testbench.sv
